// ===== hw/rtl/brute_force_k_nearest_3d_top_assert.svh =====
// Assertion macros for the checker file of the k-nearest block
`ifndef BRUTE_FORCE_K_NEAREST_3D_TOP_ASSERT_SVH
`define BRUTE_FORCE_K_NEAREST_3D_TOP_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define BFK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define BFK_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bfk_pkg.sv =====
// Types, constants and codes shared by the k-nearest block
package bfk_pkg;

    localparam int COORD_BITS   = 24;
    localparam int DIMS         = 3;
    localparam int DIST_BITS    = 50;
    localparam int SQ_BITS      = 2 * COORD_BITS;
    localparam int KEEP_BITS    = 5;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = COORD_BITS;
    localparam int KEEP_MAX_DEF = 16;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [DIST_BITS-1:0]         dist_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        logic   set_end;
    } in_item_t;

    typedef struct packed {
        coord_t near_x;
        coord_t near_y;
        coord_t near_z;
        dist_t  near_dist;
        logic   run_last;
    } out_item_t;

    // one slot of the sorted store
    typedef struct packed {
        logic   valid;
        dist_t  dist_sq;
        coord_t x;
        coord_t y;
        coord_t z;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   ins;
        logic   drain;
        entry_t cand;
    } cell_ctrl_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_QUERY_X    = 3'd0,
        CFG_QUERY_Y    = 3'd1,
        CFG_QUERY_Z    = 3'd2,
        CFG_KEEP_COUNT = 3'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_DRAIN
    } ctl_state_t;

endpackage

// ===== hw/rtl/bfk_dist.sv =====
// Three-stage squared distance pipeline: abs difference, square, sum
module bfk_dist
    import bfk_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  in_item_t in_item,
    input  coord_t   query_x,
    input  coord_t   query_y,
    input  coord_t   query_z,
    output logic     out_valid,
    output logic     out_end,
    output entry_t   out_entry
);

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  e1_reg, e2_reg, e3_reg;
    coord_t                p1_reg [DIMS];
    coord_t                p2_reg [DIMS];
    coord_t                p3_reg [DIMS];
    logic [COORD_BITS-1:0] a1_reg [DIMS];
    logic [COORD_BITS-1:0] a1_next [DIMS];
    logic [SQ_BITS-1:0]    sq2_reg [DIMS];
    dist_t                 d3_reg;
    coord_t                pin [DIMS];
    coord_t                qin [DIMS];

    assign pin[0] = in_item.point_x;
    assign pin[1] = in_item.point_y;
    assign pin[2] = in_item.point_z;
    assign qin[0] = query_x;
    assign qin[1] = query_y;
    assign qin[2] = query_z;

    // |a - b| of two signed coords always fits COORD_BITS unsigned
    always_comb begin
        logic signed [COORD_BITS:0] diff [DIMS];
        logic signed [COORD_BITS:0] mag  [DIMS];
        for (int i = 0; i < DIMS; i++) begin
            diff[i]    = (COORD_BITS+1)'(pin[i]) - (COORD_BITS+1)'(qin[i]);
            mag[i]     = diff[i][COORD_BITS] ? -diff[i] : diff[i];
            a1_next[i] = mag[i][COORD_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        e1_reg <= in_item.set_end;
        e2_reg <= e1_reg;
        e3_reg <= e2_reg;
        for (int i = 0; i < DIMS; i++) begin
            p1_reg[i]  <= pin[i];
            p2_reg[i]  <= p1_reg[i];
            p3_reg[i]  <= p2_reg[i];
            a1_reg[i]  <= a1_next[i];
            sq2_reg[i] <= SQ_BITS'(a1_reg[i]) * SQ_BITS'(a1_reg[i]);
        end
        d3_reg <= DIST_BITS'(sq2_reg[0]) + DIST_BITS'(sq2_reg[1]) + DIST_BITS'(sq2_reg[2]);
    end

    assign out_valid         = v3_reg;
    assign out_end           = e3_reg;
    assign out_entry.valid   = 1'b1;
    assign out_entry.dist_sq = d3_reg;
    assign out_entry.x       = p3_reg[0];
    assign out_entry.y       = p3_reg[1];
    assign out_entry.z       = p3_reg[2];

endmodule

// ===== hw/rtl/bfk_cell.sv =====
// One slot of the sorted insertion chain
module bfk_cell
    import bfk_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int LIM_BITS = KEEP_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [LIM_BITS-1:0] limit,
    input  cell_ctrl_t          ctrl,
    input  entry_t              left_e,
    input  logic                left_beats,
    input  entry_t              right_e,
    output entry_t              q,
    output logic                beats
);

    logic   valid_reg, valid_next;
    entry_t data_reg, data_next;
    logic   in_limit;

    assign in_limit = LIM_BITS'(IDX) < limit;
    // ties stay ahead of the newcomer
    assign beats    = valid_reg && in_limit && (data_reg.dist_sq <= ctrl.cand.dist_sq);

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.ins) begin
            if (!in_limit) begin
                valid_next = 1'b0;
            end else if (beats) begin
                valid_next = valid_reg;
            end else if (left_beats) begin
                valid_next = 1'b1;
                data_next  = ctrl.cand;
            end else begin
                valid_next = left_e.valid;
                data_next  = left_e;
            end
        end else if (ctrl.drain) begin
            valid_next = right_e.valid;
            data_next  = right_e;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_comb begin
        q       = data_reg;
        q.valid = valid_reg;
    end

endmodule

// ===== hw/rtl/brute_force_k_nearest_3d_top.sv =====
// Top level: k nearest points to a query point, by a sorted chain of cells
// Throughput: one point a cycle while no run is being flushed or read out.
// An accepted point reaches the chain through the abs difference, square and sum registers (distance pipeline).
// A run costs the set_end item, the flush of the distance pipeline, then one kept point per cycle while m_ready.
// Reset (aresetn low, synchronous): store emptied, query zero, keep_count one.
module brute_force_k_nearest_3d_top
    import bfk_pkg::*;
#(
    parameter int KEEP_MAX = KEEP_MAX_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data
);

    // limit must hold both KEEP_MAX and any 5-bit keep_count
    localparam int LIM_BITS = ($clog2(KEEP_MAX + 1) > KEEP_BITS) ?
                              $clog2(KEEP_MAX + 1) : KEEP_BITS;

    // ---- configuration registers ----
    coord_t               query_x_reg, query_y_reg, query_z_reg;
    logic [KEEP_BITS-1:0] keep_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_x_reg    <= '0;
            query_y_reg    <= '0;
            query_z_reg    <= '0;
            keep_count_reg <= KEEP_BITS'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_QUERY_X:    query_x_reg    <= cfg_wr_data[COORD_BITS-1:0];
                CFG_QUERY_Y:    query_y_reg    <= cfg_wr_data[COORD_BITS-1:0];
                CFG_QUERY_Z:    query_z_reg    <= cfg_wr_data[COORD_BITS-1:0];
                CFG_KEEP_COUNT: keep_count_reg <= cfg_wr_data[KEEP_BITS-1:0];
                default:        ; // unmapped index, write dropped
            endcase
        end
    end

    // keep_count clamped to 1..KEEP_MAX
    logic [LIM_BITS-1:0] keep_ext, limit;
    assign keep_ext = LIM_BITS'(keep_count_reg);
    always_comb begin
        if (keep_ext == '0) begin
            limit = LIM_BITS'(1);
        end else if (keep_ext > LIM_BITS'(KEEP_MAX)) begin
            limit = LIM_BITS'(KEEP_MAX);
        end else begin
            limit = keep_ext;
        end
    end

    // ---- distance pipeline ----
    logic   dist_valid, dist_end;
    entry_t dist_entry;
    logic   in_acc;

    assign in_acc = s_valid && s_ready;

    bfk_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_acc),
        .in_item   (s_data),
        .query_x   (query_x_reg),
        .query_y   (query_y_reg),
        .query_z   (query_z_reg),
        .out_valid (dist_valid),
        .out_end   (dist_end),
        .out_entry (dist_entry)
    );

    // ---- control ----
    // RUN: points stream in. FLUSH: set_end item still in the pipeline.
    // DRAIN: cell 0 presents the nearest point; the chain shifts towards it.
    ctl_state_t state_reg, state_next;
    entry_t     cell_q [KEEP_MAX];
    logic       cell_beats [KEEP_MAX];
    logic       last_item;
    logic       drain_step;
    cell_ctrl_t ctrl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        drain_step = 1'b0;
        case (state_reg)
            ST_RUN: begin
                s_ready = 1'b1;
                if (s_valid && s_data.set_end) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (dist_valid && dist_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                m_valid    = cell_q[0].valid;
                drain_step = cell_q[0].valid && m_ready;
                // an empty store ends the run too
                if (!cell_q[0].valid || (m_ready && last_item)) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    assign ctrl.ins   = dist_valid;
    assign ctrl.drain = drain_step;
    assign ctrl.cand  = dist_entry;

    // ---- insertion chain ----
    for (genvar g = 0; g < KEEP_MAX; g++) begin : g_cell
        entry_t left_e, right_e;
        logic   left_b;

        if (g == 0) begin : g_head
            assign left_e = '0;
            assign left_b = 1'b1;   // nothing ahead of the head cell
        end else begin : g_body
            assign left_e = cell_q[g-1];
            assign left_b = cell_beats[g-1];
        end

        if (g == KEEP_MAX - 1) begin : g_tail
            assign right_e = '0;
        end else begin : g_mid
            assign right_e = cell_q[g+1];
        end

        bfk_cell #(
            .IDX      (g),
            .LIM_BITS (LIM_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .limit      (limit),
            .ctrl       (ctrl),
            .left_e     (left_e),
            .left_beats (left_b),
            .right_e    (right_e),
            .q          (cell_q[g]),
            .beats      (cell_beats[g])
        );
    end

    // last of the run when nothing valid follows the head
    if (KEEP_MAX == 1) begin : g_last_one
        assign last_item = 1'b1;
    end else begin : g_last_many
        assign last_item = !cell_q[1].valid;
    end

    assign m_data.near_x    = cell_q[0].x;
    assign m_data.near_y    = cell_q[0].y;
    assign m_data.near_z    = cell_q[0].z;
    assign m_data.near_dist = cell_q[0].dist_sq;
    assign m_data.run_last  = last_item;

endmodule

// ===== hw/rtl/bfk_checker.sv =====
// Port-level checks of the k-nearest block, bound to its top level
`include "brute_force_k_nearest_3d_top_assert.svh"

module bfk_checker
    import bfk_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled result holds
    `BFK_ASSERT_NXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed under stall")

    // no new point is taken while a run is read out
    `BFK_ASSERT_NOW(a_no_in_drain, m_valid, !s_ready, "input taken during read-out")

    // the closing item shuts the input until its run is read out
    `BFK_ASSERT_NXT(a_end_closes, s_valid && s_ready && s_data.set_end, !s_ready, "input open after set_end")

    // nothing follows the last result of a run
    `BFK_ASSERT_NXT(a_last_ends, m_valid && m_ready && m_data.run_last, !m_valid, "result after run_last")

endmodule

bind brute_force_k_nearest_3d_top bfk_checker u_bfk_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
